// ===== sv/ipp_pkg.sv =====
// Shared types and constants for the IP address text parser.
// Used by the lane, datapath, controller and top-level modules; no dependencies.
package ipp_pkg;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_OVER_255     = 3'd1,
      STATUS_NO_DOT       = 3'd2,
      STATUS_NO_COLON     = 3'd3,
      STATUS_NO_SLASH     = 3'd4,
      STATUS_NO_DIGITS    = 3'd5,
      STATUS_HEX_OVERFLOW = 3'd6
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       start;   // first character of a string
      logic       step;    // a character is accepted
      logic       finish;  // close both readings after the final character
      logic       load;    // load the result register
      logic [2:0] index;   // group index of the result being loaded
   } ipp_cmd_type;

   // Per-lane commands from the datapath to each reading.
   typedef struct packed {
      logic       start;
      logic       step;
      logic       finish;
      logic [7:0] ch;
      logic       prefix_wanted;
   } ipp_lane_cmd_type;

endpackage

// ===== sv/ipp_lane.sv =====
// One reading of the address text (decimal dotted or hex colon groups).
// Depends on ipp_pkg for status codes, characters and the lane command struct.
module ipp_lane import ipp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ipp_lane_cmd_type cmd,
   input  logic             hex_mode,
   input  logic [2:0]       rd_index,
   output status_type       err_code,
   output logic [15:0]      rd_value,
   output logic [7:0]       prefix_len
);

   typedef enum logic [1:0] {
      PH_GROUPS = 2'd0,
      PH_PREFIX = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   phase_type   phase_ff, phase_in, b_phase;
   logic [3:0]  count_ff, count_in, b_count, count_inc, total;
   logic [16:0] acc_ff, acc_in, b_acc, limit;
   logic        seen_ff, seen_in, b_seen;
   status_type  err_ff, err_in, b_err;
   logic [7:0]  pacc_ff, pacc_in, b_pacc, sep;
   logic [15:0] store_ff [8];
   logic        wr_en;
   logic        dec_ok, letter_ok, hex_ok, over;
   logic [3:0]  dval;
   logic [20:0] prod, v;
   logic [11:0] pv;

   always_comb begin
      // A new string starts both readings from their cleared values.
      if (cmd.start) begin
         b_phase = PH_GROUPS;
         b_count = 4'd0;
         b_acc   = 17'd0;
         b_seen  = 1'b0;
         b_err   = STATUS_OK;
         b_pacc  = 8'd0;
      end else begin
         b_phase = phase_ff;
         b_count = count_ff;
         b_acc   = acc_ff;
         b_seen  = seen_ff;
         b_err   = err_ff;
         b_pacc  = pacc_ff;
      end

      dec_ok    = (cmd.ch >= 8'h30) && (cmd.ch <= 8'h39);
      letter_ok = ((cmd.ch >= 8'h61) && (cmd.ch <= 8'h66)) ||
                  ((cmd.ch >= 8'h41) && (cmd.ch <= 8'h46));
      hex_ok    = dec_ok || (hex_mode && letter_ok);
      dval      = dec_ok ? cmd.ch[3:0] : cmd.ch[3:0] + 4'd9;

      limit = hex_mode ? 17'h0FFFF : 17'h000FF;
      total = hex_mode ? 4'd8 : 4'd4;
      sep   = hex_mode ? CH_COLON : CH_DOT;
      prod  = hex_mode ? {b_acc, 4'b0000}
                       : ({1'b0, b_acc, 3'b000} + {3'b000, b_acc, 1'b0});
      v     = prod + {17'd0, dval};
      over  = v > {4'd0, limit};
      pv    = {1'b0, b_pacc, 3'b000} + {3'b000, b_pacc, 1'b0} + {8'd0, dval};
      count_inc = b_count + 4'd1;

      phase_in = b_phase;
      count_in = b_count;
      acc_in   = b_acc;
      seen_in  = b_seen;
      err_in   = b_err;
      pacc_in  = b_pacc;
      wr_en    = 1'b0;

      if (cmd.step && b_err == STATUS_OK && b_phase != PH_DONE) begin
         if (b_phase == PH_GROUPS) begin
            if (hex_ok) begin
               seen_in = 1'b1;
               if (over) begin
                  acc_in = limit + 17'd1;
                  if (hex_mode) begin
                     err_in = STATUS_HEX_OVERFLOW;
                  end else begin
                     err_in = STATUS_OVER_255;
                  end
               end else begin
                  acc_in = v[16:0];
               end
            end else if (!b_seen) begin
               err_in = STATUS_NO_DIGITS;
            end else begin
               wr_en    = 1'b1;
               count_in = count_inc;
               acc_in   = 17'd0;
               seen_in  = 1'b0;
               if (count_inc < total) begin
                  if (cmd.ch != sep) begin
                     if (hex_mode) begin
                        err_in = STATUS_NO_COLON;
                     end else begin
                        err_in = STATUS_NO_DOT;
                     end
                  end
               end else if (cmd.prefix_wanted) begin
                  if (cmd.ch == CH_SLASH) begin
                     phase_in = PH_PREFIX;
                  end else begin
                     err_in = STATUS_NO_SLASH;
                  end
               end else begin
                  phase_in = PH_DONE;
               end
            end
         end else begin
            // Prefix length digits, always decimal, saturating at 255.
            if (dec_ok) begin
               pacc_in = (pv > 12'd255) ? 8'd255 : pv[7:0];
               seen_in = 1'b1;
            end else if (!b_seen) begin
               err_in = STATUS_NO_DIGITS;
            end else begin
               phase_in = PH_DONE;
            end
         end
      end else if (cmd.finish && b_err == STATUS_OK && b_phase != PH_DONE) begin
         if (!b_seen) begin
            err_in = STATUS_NO_DIGITS;
         end else begin
            if (b_phase == PH_GROUPS) begin
               wr_en    = 1'b1;
               count_in = count_inc;
               if (count_inc < total) begin
                  if (hex_mode) begin
                     err_in = STATUS_NO_COLON;
                  end else begin
                     err_in = STATUS_NO_DOT;
                  end
               end else if (cmd.prefix_wanted) begin
                  err_in = STATUS_NO_SLASH;
               end
            end
            phase_in = PH_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_GROUPS;
         count_ff <= 4'd0;
         acc_ff   <= 17'd0;
         seen_ff  <= 1'b0;
         err_ff   <= STATUS_OK;
         pacc_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
         seen_ff  <= seen_in;
         err_ff   <= err_in;
         pacc_ff  <= pacc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[b_count[2:0]] <= b_acc[15:0];
      end
   end

   assign err_code   = err_ff;
   assign rd_value   = store_ff[rd_index];
   assign prefix_len = pacc_ff;

endmodule

// ===== sv/ipp_datapath.sv =====
// Datapath: both readings side by side, the colon test and the result register.
// Depends on ipp_pkg and instantiates ipp_lane twice.
module ipp_datapath import ipp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ipp_cmd_type cmd,
   input  logic [7:0]  req_ch,
   input  logic        req_expect_prefix,
   output status_type  rsp_status,
   output logic        rsp_is_v6,
   output logic [2:0]  rsp_index,
   output logic [15:0] rsp_value,
   output logic [7:0]  rsp_prefix,
   output logic        rsp_last,
   output logic        last_result
);

   logic             colon_ff, colon_in;
   logic             pw_ff, pw_in;
   ipp_lane_cmd_type lane_cmd;
   status_type       v4_err, v6_err, sel_err;
   logic [15:0]      v4_value, v6_value;
   logic [7:0]       v4_prefix, v6_prefix;
   status_type       status_ff;
   logic             is_v6_ff, last_ff;
   logic [2:0]       index_ff;
   logic [15:0]      value_ff;
   logic [7:0]       prefix_ff;

   always_comb begin
      colon_in = colon_ff;
      pw_in    = pw_ff;
      if (cmd.start) begin
         colon_in = 1'b0;
         pw_in    = req_expect_prefix;
      end
      if (cmd.step && req_ch == CH_COLON) begin
         colon_in = 1'b1;
      end
   end

   assign lane_cmd = '{start: cmd.start, step: cmd.step, finish: cmd.finish,
                       ch: req_ch, prefix_wanted: pw_in};

   ipp_lane u_v4 (
      .clock      (clock),
      .reset      (reset),
      .cmd        (lane_cmd),
      .hex_mode   (1'b0),
      .rd_index   (cmd.index),
      .err_code   (v4_err),
      .rd_value   (v4_value),
      .prefix_len (v4_prefix)
   );

   ipp_lane u_v6 (
      .clock      (clock),
      .reset      (reset),
      .cmd        (lane_cmd),
      .hex_mode   (1'b1),
      .rd_index   (cmd.index),
      .err_code   (v6_err),
      .rd_value   (v6_value),
      .prefix_len (v6_prefix)
   );

   assign sel_err     = colon_ff ? v6_err : v4_err;
   assign last_result = (sel_err != STATUS_OK) ||
                        (cmd.index == (colon_ff ? 3'd7 : 3'd3));

   always_ff @(posedge clock) begin
      if (reset) begin
         colon_ff <= 1'b0;
         pw_ff    <= 1'b0;
      end else begin
         colon_ff <= colon_in;
         pw_ff    <= pw_in;
      end
   end

   // An error result carries the status, is_v6 and last; group fields read as zero.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff <= sel_err;
         is_v6_ff  <= colon_ff;
         last_ff   <= last_result;
         if (sel_err != STATUS_OK) begin
            index_ff  <= 3'd0;
            value_ff  <= 16'd0;
            prefix_ff <= 8'd0;
         end else begin
            index_ff  <= cmd.index;
            value_ff  <= colon_ff ? v6_value : v4_value;
            prefix_ff <= pw_ff ? (colon_ff ? v6_prefix : v4_prefix) : 8'd0;
         end
      end
   end

   assign rsp_status = status_ff;
   assign rsp_is_v6  = is_v6_ff;
   assign rsp_index  = index_ff;
   assign rsp_value  = value_ff;
   assign rsp_prefix = prefix_ff;
   assign rsp_last   = last_ff;

endmodule

// ===== sv/ipp_ctrl.sv =====
// Controller: string framing, the closing step and the result sequencer.
// Depends on ipp_pkg for the command struct.
module ipp_ctrl import ipp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tlast,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        last_result,
   output ipp_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_TEXT,
      S_FINISH,
      S_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic       valid_ff, valid_in;
   logic [2:0] index_ff, index_in;
   logic       accept, out_free;

   assign req_tready = (state_ff == S_IDLE) || (state_ff == S_TEXT);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      index_in   = index_ff;
      cmd.start  = accept && (state_ff == S_IDLE);
      cmd.step   = accept;
      cmd.finish = (state_ff == S_FINISH);
      cmd.load   = (state_ff == S_EMIT) && out_free;
      cmd.index  = index_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = req_tlast ? S_FINISH : S_TEXT;
            end
         end
         S_TEXT: begin
            if (accept && req_tlast) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            state_in = S_EMIT;
            index_in = 3'd0;
         end
         S_EMIT: begin
            if (out_free) begin
               index_in = index_ff + 3'd1;
               if (last_result) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cmd.load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         index_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         index_ff <= index_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

// ===== sv/ip_address_text_parser_top.sv =====
// IP address text parser, top level. Takes one character per cycle while input
// is not held off; the final character of a string is followed by a closing
// step, then 4 (IPv4), 8 (IPv6) or 1 (error) results, one per cycle while the
// result side is ready. The first result is loaded in S_EMIT, after S_FINISH.
// Input is held off during the closing and result cycles only.
// Synchronous active-high reset clears the controller and parse state; the
// group stores are not reset.
module ip_address_text_parser_top import ipp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch[7:0]
   input  logic        req_tlast,   // end_of_text
   input  logic [0:0]  req_tuser,   // expect_prefix[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // group_index[2:0], group_value[18:3],
                                    // prefix_len[26:19], zero[31:27]
   output logic        rsp_tlast,   // last
   output logic [3:0]  rsp_tuser    // status[2:0], is_v6[3]
);

   ipp_cmd_type cmd;
   logic        last_result;
   status_type  rsp_status;
   logic        rsp_is_v6;
   logic [2:0]  rsp_index;
   logic [15:0] rsp_value;
   logic [7:0]  rsp_prefix;

   ipp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tlast   (req_tlast),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .last_result (last_result),
      .cmd         (cmd)
   );

   ipp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_ch            (req_tdata),
      .req_expect_prefix (req_tuser[0]),
      .rsp_status        (rsp_status),
      .rsp_is_v6         (rsp_is_v6),
      .rsp_index         (rsp_index),
      .rsp_value         (rsp_value),
      .rsp_prefix        (rsp_prefix),
      .rsp_last          (rsp_tlast),
      .last_result       (last_result)
   );

   assign rsp_tdata = {5'd0, rsp_prefix, rsp_value, rsp_index};
   assign rsp_tuser = {rsp_is_v6, rsp_status};

endmodule
